// ===== rtl/core/mbss_pkg.sv =====
// Shared types and constants for the masked byte signature scanner.
package mbss_pkg;

  // Longest signature the window holds
  localparam int PATTERN_MAX = 32;
  // Width of the region offset counter
  localparam int OFFSET_BITS = 24;
  // Cells in the chain: the signature registers hold at most 32 bytes
  localparam int SIG_LIMIT   = (PATTERN_MAX < 32) ? PATTERN_MAX : 32;
  // Bits that select one cell of the chain
  localparam int LEN_IDX_W   = (SIG_LIMIT > 1) ? $clog2(SIG_LIMIT) : 1;
  // Width of the pattern_length register
  localparam int LEN_W       = 6;
  localparam int ADDR_W      = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_0_7   = 3'd0,
    REG_PATTERN_8_15  = 3'd1,
    REG_PATTERN_16_23 = 3'd2,
    REG_PATTERN_24_31 = 3'd3,
    REG_CARE_MASK     = 3'd4,
    REG_PATTERN_LEN   = 3'd5,
    REG_BASE_ADDRESS  = 3'd6
  } reg_index_t;

  // One input request: a byte of the region
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  // One result request
  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] match_address;
  } out_item_t;

  // Byte broadcast along the cell chain
  typedef struct packed {
    logic       shift;
    logic [7:0] data;
  } feed_t;

endpackage

// ===== rtl/core/masked_byte_signature_scanner.sv =====
// Top level: configuration, region offset tracking and result register.
// Latency: a result is registered at the edge that accepts the byte closing the
//   match (or the last byte of a region with no match) and is offered on the next cycle.
// Throughput: one byte per cycle; each cell updates its partial match on every accepted byte.
//   Input stalls only while a result waits in the output register under stall.
// Reset: synchronous; clears cell flags, offset state and the result valid flag,
//   and loads configuration defaults (zero signature and base, care mask all ones, length one).
module masked_byte_signature_scanner (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  mbss_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output mbss_pkg::out_item_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mbss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mbss_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import mbss_pkg::*;

  localparam logic [OFFSET_BITS-1:0] COUNT_MAX = '1;

  logic [CFG_DATA_W-1:0]  pattern_word [4];
  logic [31:0]            care_mask;
  logic [LEN_W-1:0]       len_eff;
  logic [ADDR_W-1:0]      base_address;

  logic [OFFSET_BITS-1:0] seen;
  logic                   reported;

  logic [LEN_W-1:0]       cfg_len;
  logic [LEN_W-1:0]       cfg_len_clamped;
  logic [255:0]           pattern_flat;
  logic [LEN_W-1:0]       len_m1;
  logic                   in_accept;
  logic                   counting;
  logic [OFFSET_BITS-1:0] seen_inc;
  logic                   chain_match;
  logic                   match;
  logic                   emit;
  logic [OFFSET_BITS-1:0] start;
  feed_t                  feed;
  out_item_t              result;

  assign cfg_ready = 1'b1;

  // Clamp the written length into one to the number of cells
  assign cfg_len = cfg_data[LEN_W-1:0];
  always_comb begin
    cfg_len_clamped = cfg_len;
    if (cfg_len == '0) begin
      cfg_len_clamped = LEN_W'(1);
    end else if (cfg_len > LEN_W'(SIG_LIMIT)) begin
      cfg_len_clamped = LEN_W'(SIG_LIMIT);
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < 4; w++) begin
        pattern_word[w] <= '0;
      end
      care_mask    <= '1;
      len_eff      <= LEN_W'(1);
      base_address <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PATTERN_0_7:   pattern_word[0] <= cfg_data;
        REG_PATTERN_8_15:  pattern_word[1] <= cfg_data;
        REG_PATTERN_16_23: pattern_word[2] <= cfg_data;
        REG_PATTERN_24_31: pattern_word[3] <= cfg_data;
        REG_CARE_MASK:     care_mask       <= cfg_data[31:0];
        REG_PATTERN_LEN:   len_eff         <= cfg_len_clamped;
        REG_BASE_ADDRESS:  base_address    <= cfg_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  assign pattern_flat = {pattern_word[3], pattern_word[2], pattern_word[1], pattern_word[0]};
  assign len_m1       = len_eff - LEN_W'(1);

  // Accept while the result register is free or draining
  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;

  // Broadcast each accepted byte down the chain
  assign feed.shift = in_accept;
  assign feed.data  = in_data.data_byte;

  mbss_cell_chain u_chain (
    .clk       (clk),
    .rst       (rst),
    .feed      (feed),
    .sig_bytes (pattern_flat[SIG_LIMIT*8-1:0]),
    .care      (care_mask[SIG_LIMIT-1:0]),
    .last_idx  (len_m1[LEN_IDX_W-1:0]),
    .match     (chain_match)
  );

  // Match only once the whole signature lies inside the region
  assign counting = ~reported & (seen != COUNT_MAX);
  assign seen_inc = seen + OFFSET_BITS'(1);
  assign match    = counting & chain_match & (seen_inc >= OFFSET_BITS'(len_eff));
  assign start    = seen_inc - OFFSET_BITS'(len_eff);
  assign emit     = match | (in_data.last_byte & ~reported);

  always_comb begin
    result.found         = match;
    result.match_address = match ? (base_address + ADDR_W'(start)) : '0;
  end

  // Advance the region offset; drop the region state on its last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      seen     <= '0;
      reported <= 1'b0;
    end else if (in_accept) begin
      if (in_data.last_byte) begin
        seen     <= '0;
        reported <= 1'b0;
      end else begin
        if (counting) begin
          seen <= seen_inc;
        end
        reported <= reported | match;
      end
    end
  end

  // Result register: load on an emitting request, clear once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && emit) begin
      out_data <= result;
    end
  end

  // A region's last byte always restarts the offset tracking
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    in_accept && in_data.last_byte |=> (seen == '0) && !reported)
    else $error("region state not cleared after last byte");

  // Once a match is reported the offset stays put until the region ends
  a_reported_holds: assert property (@(posedge clk) disable iff (rst)
    in_accept && reported && !in_data.last_byte |=> reported && $stable(seen))
    else $error("offset moved after a reported match");

  // An unsaturated count moves by one on every non-final byte until a match is reported
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    in_accept && counting && !in_data.last_byte |=>
      seen == OFFSET_BITS'($past(seen) + OFFSET_BITS'(1)))
    else $error("offset counter skipped");

  // A not-found result carries a zero address
  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.found |-> out_data.match_address == '0)
    else $error("not-found result with nonzero address");

endmodule

// ===== rtl/core/mbss_cell.sv =====
// One cell of the match chain: tracks a partial match up to its signature byte.
module mbss_cell (
  input  logic           clk,
  input  logic           rst,
  input  mbss_pkg::feed_t feed,
  input  logic [7:0]     sig_byte,
  input  logic           care,
  input  logic           prev_flag,
  output logic           hit,
  output logic           flag
);
  import mbss_pkg::*;

  // Extend the neighbour's partial match by the incoming byte
  assign hit = prev_flag & (~care | (feed.data == sig_byte));

  // Hold the partial match for the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      flag <= 1'b0;
    end else if (feed.shift) begin
      flag <= hit;
    end
  end

endmodule

// ===== rtl/core/mbss_cell_chain.sv =====
// Row of match cells and selection of the cell at the signature's end.
module mbss_cell_chain (
  input  logic                              clk,
  input  logic                              rst,
  input  mbss_pkg::feed_t                   feed,
  input  logic [mbss_pkg::SIG_LIMIT*8-1:0]  sig_bytes,
  input  logic [mbss_pkg::SIG_LIMIT-1:0]    care,
  input  logic [mbss_pkg::LEN_IDX_W-1:0]    last_idx,
  output logic                              match
);
  import mbss_pkg::*;

  logic [SIG_LIMIT-1:0] hit;
  logic [SIG_LIMIT-1:0] flag;
  logic [SIG_LIMIT-1:0] prev;

  // First cell always starts a fresh match
  assign prev[0] = 1'b1;

  for (genvar i = 0; i < SIG_LIMIT; i++) begin : g_cell
    if (i > 0) begin : g_link
      assign prev[i] = flag[i-1];
    end
    mbss_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .feed      (feed),
      .sig_byte  (sig_bytes[i*8 +: 8]),
      .care      (care[i]),
      .prev_flag (prev[i]),
      .hit       (hit[i]),
      .flag      (flag[i])
    );
  end

  // Pick the cell that closes a signature of the current length
  assign match = hit[last_idx];

endmodule

// ===== sim/mbss_checker.sv =====
// Scoreboard for the masked byte signature scanner: mirrors the registers, predicts and compares.
module mbss_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  mbss_pkg::in_item_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  mbss_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [mbss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbss_pkg::CFG_DATA_W-1:0] cfg_data,
  output int unsigned                     failures,
  output int unsigned                     outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import mbss_pkg::*;

  // Register mirror
  logic [8*32-1:0]        sig_copy;
  logic [31:0]            mask_copy;
  logic [LEN_W-1:0]       len_copy;
  logic [ADDR_W-1:0]      base_copy;

  // Scan state: newest byte in slot 0
  logic [7:0]             window [PATTERN_MAX];
  logic [OFFSET_BITS-1:0] seen;
  logic                   reported;

  out_item_t              pending_hits [$];
  int unsigned            fail_total;

  // Advance the scan by one byte and queue whatever result it causes
  task automatic scan_byte(input in_item_t item);
    int unsigned span;
    bit          hit;
    out_item_t   res;
    if (!reported && seen != {OFFSET_BITS{1'b1}}) begin
      span = (len_copy == 0) ? 1 : ((len_copy > SIG_LIMIT) ? SIG_LIMIT : len_copy);
      for (int j = PATTERN_MAX - 1; j > 0; j--) window[j] = window[j-1];
      window[0] = item.data_byte;
      seen = seen + 1'b1;
      if (seen >= span) begin
        hit = 1'b1;
        for (int i = 0; i < span; i++) begin
          if (mask_copy[i] && window[span-1-i] != sig_copy[8*i +: 8]) hit = 1'b0;
        end
        if (hit) begin
          res.found = 1'b1;
          res.match_address = base_copy + ADDR_W'(seen - span);
          pending_hits.push_back(res);
          reported = 1'b1;
        end
      end
    end
    // The last byte closes the region whatever happened in it
    if (item.last_byte) begin
      if (!reported) begin
        res.found = 1'b0;
        res.match_address = '0;
        pending_hits.push_back(res);
      end
      seen = '0;
      reported = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      sig_copy  = '0;
      mask_copy = '1;
      len_copy  = LEN_W'(1);
      base_copy = '0;
      for (int j = 0; j < PATTERN_MAX; j++) window[j] = 8'h00;
      seen      = '0;
      reported  = 1'b0;
      pending_hits.delete();
      fail_total = 0;
    end else begin
      // Track register writes; unknown indexes are dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PATTERN_0_7:   sig_copy[63:0]    = cfg_data;
          REG_PATTERN_8_15:  sig_copy[127:64]  = cfg_data;
          REG_PATTERN_16_23: sig_copy[191:128] = cfg_data;
          REG_PATTERN_24_31: sig_copy[255:192] = cfg_data;
          REG_CARE_MASK:     mask_copy         = cfg_data[31:0];
          REG_PATTERN_LEN:   len_copy          = cfg_data[LEN_W-1:0];
          REG_BASE_ADDRESS:  base_copy         = cfg_data[ADDR_W-1:0];
          default: ;
        endcase
      end

      // Compare a delivered result against the oldest prediction
      if (out_valid && !out_stall) begin
        if (pending_hits.size() == 0) begin
          $error("unexpected result: found %0d match_address %h",
                 out_data.found, out_data.match_address);
          fail_total++;
        end else begin
          want = pending_hits.pop_front();
          if (out_data.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, out_data.found);
            fail_total++;
          end
          if (out_data.match_address !== want.match_address) begin
            $error("match_address: expected %h, actual %h",
                   want.match_address, out_data.match_address);
            fail_total++;
          end
        end
      end

      if (in_valid && !in_stall) scan_byte(in_data);
    end
    failures    <= fail_total;
    outstanding <= pending_hits.size();
  end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the masked byte signature scanner: clock, reset, stimulus and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mbss_pkg::*;

  localparam int unsigned         CYCLE_LIMIT  = 400000;
  localparam int unsigned         PHASES       = 14;
  localparam int unsigned         PHASE_ITEMS  = 97;
  localparam logic [CFG_IDX_W-1:0] UNUSED_INDEX = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int unsigned           failures;
  int unsigned           outstanding;
  int unsigned           cycle_count = 0;

  // Stimulus copy of the current setting, used only to shape the regions
  logic [8*32-1:0]       sig_img;
  logic [31:0]           mask_img;
  int unsigned           span_img;
  bit                    calm = 1'b0;

  masked_byte_signature_scanner dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mbss_checker scoreboard (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .failures    (failures),
    .outstanding (outstanding)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Mostly short idle stretches, now and then a long one
  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side back-pressure
  initial begin
    int unsigned hold;
    bit          level;
    forever begin
      @(posedge clk);
      hold = idle_length();
      level = (hold != 0);
      if (!level) hold = $urandom_range(1, 30);
      out_stall <= level;
      repeat (hold - 1) @(posedge clk);
    end
  end

  // Offer one byte request and hold it until taken
  task automatic push_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    in_item_t    item;
    gap = idle_length();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.data_byte = b;
    item.last_byte = last;
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Hold off the sender until every predicted result has been delivered
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Load a full setting; spare upper bits carry junk that must be dropped
  task automatic apply_setting(input logic [8*32-1:0] sig, input logic [31:0] mask,
                               input logic [LEN_W-1:0] plen, input logic [ADDR_W-1:0] base);
    logic [CFG_DATA_W-1:0] word;
    repeat (4) @(posedge clk);
    write_reg(REG_PATTERN_0_7, sig[63:0]);
    write_reg(REG_PATTERN_8_15, sig[127:64]);
    write_reg(REG_PATTERN_16_23, sig[191:128]);
    write_reg(REG_PATTERN_24_31, sig[255:192]);
    word = {$urandom, $urandom};
    word[31:0] = mask;
    write_reg(REG_CARE_MASK, word);
    word = {$urandom, $urandom};
    word[LEN_W-1:0] = plen;
    write_reg(REG_PATTERN_LEN, word);
    word = {$urandom, $urandom};
    word[ADDR_W-1:0] = base;
    write_reg(REG_BASE_ADDRESS, word);
    cfg_valid <= 1'b0;
    sig_img  = sig;
    mask_img = mask;
    span_img = (plen == 0) ? 1 : ((plen > SIG_LIMIT) ? SIG_LIMIT : plen);
  endtask

  // One region: the signature planted whole, planted with a damaged byte, or plain noise
  task automatic scan_region(input int unsigned len_r);
    int unsigned kind, at, rel, broken;
    logic [7:0]  b;
    kind   = $urandom_range(0, 9);
    at     = (len_r >= span_img) ? $urandom_range(0, len_r - span_img) : 0;
    broken = $urandom_range(0, span_img - 1);
    for (int unsigned p = 0; p < len_r; p++) begin
      b = $urandom_range(0, 255);
      if (kind < 8 && len_r >= span_img && p >= at && p < at + span_img) begin
        rel = p - at;
        if (mask_img[rel] || $urandom_range(0, 3) == 0) b = sig_img[8*rel +: 8];
        if (kind >= 6 && rel == broken) b = b ^ (8'd1 << $urandom_range(0, 7));
      end
      push_byte(b, p == len_r - 1);
    end
  endtask

  initial begin
    // bit 8 marks the region's last byte
    logic [8:0]       script [$];
    logic [8*32-1:0]  sig;
    logic [31:0]      mask;
    logic [LEN_W-1:0] plen;
    logic [ADDR_W-1:0] base;
    int unsigned      phase_items, len_r, r;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Defaults: one byte of zero, cared for
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    wait_drained();

    // Directed setting: DE AD BE, wildcard fourth byte, base just below the wrap
    repeat (4) @(posedge clk);
    write_reg(UNUSED_INDEX, {$urandom, $urandom});
    apply_setting({{28{8'h00}}, 32'hEFBE_ADDE}, 32'hFFFF_FFF7, 6'd4, 32'hFFFF_FFFE);
    script = '{
      // too short to match
      9'h0DE, 9'h1AD,
      // match closing on the last byte
      9'h0DE, 9'h0AD, 9'h0BE, 9'h112,
      // match at offset one, later bytes ignored
      9'h000, 9'h0DE, 9'h0AD, 9'h0BE, 9'h055, 9'h0DE, 9'h0AD, 9'h0BE, 9'h0EF, 9'h1FF,
      // match whose address wraps to zero
      9'h011, 9'h022, 9'h0DE, 9'h0AD, 9'h0BE, 9'h100
    };
    foreach (script[k]) push_byte(script[k][7:0], script[k][8]);

    // Random phases, each under its own setting
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      sig  = {8{$urandom}};
      mask = $urandom;
      r    = $urandom_range(0, 9);
      plen = (r < 7) ? LEN_W'($urandom_range(1, 8)) : LEN_W'($urandom_range(9, 32));
      base = $urandom;
      case (phase)
        1: plen = 6'd0;
        2: plen = 6'd32;
        3: plen = 6'd63;
        4: plen = 6'd33;
        5: mask = 32'h0000_0000;
        6: base = 32'hFFFF_FFFF;
        7: begin
          plen = 6'd1;
          sig  = '1;
        end
        8: base = 32'h0000_0000;
        9: sig  = '0;
        default: ;
      endcase
      if (phase % 5 == 0 && phase != 5) mask = 32'hFFFF_FFFF;
      apply_setting(sig, mask, plen, base);
      calm = (phase % 4 == 3);

      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 80) len_r = $urandom_range(1, span_img + 8);
        else if (r < 95) len_r = $urandom_range(span_img, 2 * span_img + 20);
        else len_r = $urandom_range(60, 150);
        scan_region(len_r);
        phase_items += len_r;
        if ($urandom_range(0, 24) == 0) wait_drained();
      end
    end

    // Drain and let the pipeline settle
    wait_drained();
    repeat (8) @(posedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/mbss_pkg.sv
rtl/core/mbss_cell.sv
rtl/core/mbss_cell_chain.sv
rtl/core/masked_byte_signature_scanner.sv
sim/mbss_checker.sv
sim/tb.sv
